### hdl/time_window_descriptor_ring_unit_macros.svh
// Assertion macros for the descriptor ring unit.
// Expects clk and arst_n in the scope of each use.
`ifndef TIME_WINDOW_DESCRIPTOR_RING_UNIT_MACROS_SVH
`define TIME_WINDOW_DESCRIPTOR_RING_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TWDR_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
`define TWDR_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define TWDR_ASSERT(lbl, expr, msg)
`define TWDR_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### hdl/twdr_pkg.sv
// Shared types and constants of the descriptor ring unit.
// No dependencies.
package twdr_pkg;

	localparam int DESC_DEPTH = 1024;
	localparam int DESC_AW    = 10;
	localparam int CNT_W      = DESC_AW + 1;
	localparam int DATA_AW    = 16;

	typedef enum logic [2:0] {
		CMD_PUSH    = 3'd0,
		CMD_CHECK   = 3'd1,
		CMD_FIND    = 3'd2,
		CMD_ACK     = 3'd3,
		CMD_MONITOR = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_TRY_LATER    = 3'd1,
		ST_FAILED       = 3'd2,
		ST_OUT_OF_RANGE = 3'd3,
		ST_FULL         = 3'd4
	} status_t;

	typedef enum logic {
		CFG_OVERLAP_BEFORE = 1'b0,
		CFG_OVERLAP_AFTER  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		cmd_t        cmd;
		logic [63:0] tv;
		logic [63:0] lo_t;
		logic [63:0] hi_t;
		logic [63:0] offset;
		logic [31:0] size;
		logic        ovf;
	} req_t;

	typedef struct packed {
		logic [63:0] time_v;
		logic [63:0] offset;
		logic [31:0] size;
		logic        ovf;
	} slot_t;

	typedef struct packed {
		status_t            status;
		logic [63:0]        begin_index;
		logic [63:0]        end_index;
		logic [CNT_W-1:0]   slice_count;
		logic [63:0]        payload_begin;
		logic [63:0]        payload_end;
		logic               overflow_any;
		logic [DESC_AW-1:0] desc_read_slot;
		logic [DATA_AW-1:0] data_read_byte;
		logic [CNT_W-1:0]   desc_used;
		logic [63:0]        data_used;
		logic [63:0]        latest_time;
	} res_t;

endpackage

### hdl/twdr_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module twdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

### hdl/twdr_front.sv
// Front end: config registers, window bounds, two-word request queue.
// Depends on twdr_pkg.
module twdr_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic [2:0]        cmd,
	input  logic [63:0]       time_value,
	input  logic [31:0]       duration,
	input  logic [63:0]       payload_offset,
	input  logic [31:0]       data_size,
	input  logic              overflow_mark,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [31:0]       cfg_data,
	output logic              req_valid,
	input  logic              req_take,
	output twdr_pkg::req_t    req_head
);
	import twdr_pkg::*;

	logic [31:0] ob_q, oa_q;
	req_t        q_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  cnt_q;
	logic        acc;
	req_t        w_req;

	assign full      = (cnt_q == 2'd2);
	assign acc       = push && !full;
	assign req_valid = (cnt_q != 2'd0);
	assign req_head  = q_q[rd_ptr_q];

	always_comb begin
		w_req.cmd    = cmd_t'(cmd);
		w_req.tv     = time_value;
		w_req.lo_t   = time_value - {32'd0, ob_q};
		w_req.hi_t   = time_value + {32'd0, duration} + {32'd0, oa_q};
		w_req.offset = payload_offset;
		w_req.size   = data_size;
		w_req.ovf    = overflow_mark;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			q_q[wr_ptr_q] <= w_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ob_q     <= '0;
			oa_q     <= '0;
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_OVERLAP_BEFORE: ob_q <= cfg_data;
					CFG_OVERLAP_AFTER:  oa_q <= cfg_data;
				endcase
			end
			if (acc) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (req_take) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, acc} - {1'b0, req_take};
		end
	end
endmodule

### hdl/twdr_back.sv
// Back end: descriptor memory, ring indices, search sequencer, result register.
// Depends on twdr_pkg, twdr_ram and the assertion macro header.
`include "time_window_descriptor_ring_unit_macros.svh"
module twdr_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_take,
	input  twdr_pkg::req_t req_head,
	output logic           res_valid,
	input  logic           pop,
	output twdr_pkg::res_t res
);
	import twdr_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE, S_DISP, S_SRCH, S_SRCH_CMP,
		S_CHK_R, S_CHK_RW, S_CHK_W, S_CHK_WW,
		S_F_OFF, S_F_OFFW, S_F_END, S_F_ENDW, S_SCAN, S_SCANW,
		S_A_RD, S_A_W, S_A_OUT,
		S_MON_W, S_MON_WW, S_MON_R, S_MON_RW,
		S_DONE
	} state_t;

	state_t           state_q;
	req_t             req_q;
	res_t             acc_q, res_q;
	logic             res_valid_q;
	logic [63:0]      r_q, w_q, drp_q;
	logic [63:0]      first_q, key_q, m_q, b_q, e_q, i_q;
	logic [CNT_W-1:0] n_q;
	logic             upper_q;

	logic               ram_we;
	logic [DESC_AW-1:0] ram_addr;
	logic [$bits(slot_t)-1:0] ram_rdata;
	slot_t              rd;
	logic [63:0]        diff, first_m1, m_next, rd_end;
	logic [CNT_W-1:0]   half;
	logic               go_right;

	twdr_ram #(.WIDTH($bits(slot_t)), .DEPTH(DESC_DEPTH)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata ({req_q.tv, req_q.offset, req_q.size, req_q.ovf}),
		.rdata (ram_rdata)
	);

	assign rd       = slot_t'(ram_rdata);
	assign rd_end   = rd.offset + {32'd0, rd.size};
	assign diff     = w_q - r_q;
	assign first_m1 = first_q - 64'd1;
	assign half     = n_q >> 1;
	assign m_next   = first_q + {{(64-CNT_W){1'b0}}, half};
	assign go_right = upper_q ? !(key_q < rd.time_v) : (rd.time_v < key_q);
	assign req_take = (state_q == S_IDLE) && req_valid;
	assign ram_we   = (state_q == S_DISP) && (req_q.cmd == CMD_PUSH) &&
		(diff < 64'(DESC_DEPTH));
	assign res_valid = res_valid_q;
	assign res       = res_q;

	always_comb begin
		unique case (state_q)
			S_SRCH:            ram_addr = m_next[DESC_AW-1:0];
			S_CHK_R, S_MON_R:  ram_addr = r_q[DESC_AW-1:0];
			S_CHK_W, S_MON_W:  ram_addr = w_q[DESC_AW-1:0] - DESC_AW'(1);
			S_F_OFF:           ram_addr = b_q[DESC_AW-1:0];
			S_F_END:           ram_addr = e_q[DESC_AW-1:0] - DESC_AW'(1);
			S_SCAN:            ram_addr = i_q[DESC_AW-1:0];
			S_A_RD:            ram_addr = b_q[DESC_AW-1:0] - DESC_AW'(1);
			default:           ram_addr = w_q[DESC_AW-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			r_q         <= '0;
			w_q         <= '0;
			drp_q       <= '0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						req_q   <= req_head;
						acc_q   <= '0;
						state_q <= S_DISP;
					end
				end
				S_DISP: begin
					unique case (req_q.cmd)
						CMD_PUSH: begin
							if (ram_we) begin
								w_q <= w_q + 64'd1;
							end else begin
								acc_q.status <= ST_FULL;
							end
							state_q <= S_DONE;
						end
						CMD_CHECK: begin
							if (diff == 64'd0) begin
								acc_q.status <= ST_TRY_LATER;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_CHK_R;
							end
						end
						CMD_FIND, CMD_ACK: begin
							first_q <= r_q;
							n_q     <= CNT_W'(diff);
							key_q   <= req_q.lo_t;
							upper_q <= 1'b1;
							state_q <= S_SRCH;
						end
						CMD_MONITOR: begin
							state_q <= (diff == 64'd0) ? S_DONE : S_MON_W;
						end
						default: state_q <= S_DONE;
					endcase
				end
				S_SRCH: begin
					if (n_q != '0) begin
						m_q     <= m_next;
						state_q <= S_SRCH_CMP;
					end else if (req_q.cmd == CMD_ACK) begin
						b_q     <= first_m1;
						state_q <= (first_q != r_q && first_m1 != r_q) ? S_A_RD : S_A_OUT;
					end else if (first_q == r_q || first_q == w_q) begin
						acc_q.status <= ST_OUT_OF_RANGE;
						state_q      <= S_DONE;
					end else if (upper_q) begin
						b_q     <= first_m1;
						first_q <= first_m1;
						n_q     <= CNT_W'(w_q - first_m1);
						key_q   <= req_q.hi_t;
						upper_q <= 1'b0;
					end else begin
						e_q               <= first_q;
						acc_q.begin_index <= b_q;
						acc_q.end_index   <= first_q;
						acc_q.slice_count <= CNT_W'(first_q - b_q);
						state_q           <= S_F_OFF;
					end
				end
				S_SRCH_CMP: begin
					if (go_right) begin
						first_q <= m_q + 64'd1;
						n_q     <= n_q - half - CNT_W'(1);
					end else begin
						n_q <= half;
					end
					state_q <= S_SRCH;
				end
				S_CHK_R: state_q <= S_CHK_RW;
				S_CHK_RW: begin
					if (req_q.lo_t < rd.time_v) begin
						acc_q.status <= ST_FAILED;
						state_q      <= S_DONE;
					end else begin
						state_q <= S_CHK_W;
					end
				end
				S_CHK_W: state_q <= S_CHK_WW;
				S_CHK_WW: begin
					if (req_q.hi_t >= rd.time_v) begin
						acc_q.status <= ST_TRY_LATER;
					end
					state_q <= S_DONE;
				end
				S_F_OFF: state_q <= S_F_OFFW;
				S_F_OFFW: begin
					acc_q.payload_begin <= rd.offset;
					if (e_q == b_q) begin
						acc_q.payload_end <= rd.offset;
						state_q           <= S_DONE;
					end else begin
						state_q <= S_F_END;
					end
				end
				S_F_END: state_q <= S_F_ENDW;
				S_F_ENDW: begin
					acc_q.payload_end <= rd_end;
					i_q               <= b_q;
					state_q           <= S_SCAN;
				end
				S_SCAN: state_q <= S_SCANW;
				S_SCANW: begin
					if (rd.ovf) begin
						acc_q.overflow_any <= 1'b1;
						state_q            <= S_DONE;
					end else if (i_q + 64'd1 == e_q) begin
						state_q <= S_DONE;
					end else begin
						i_q     <= i_q + 64'd1;
						state_q <= S_SCAN;
					end
				end
				S_A_RD: state_q <= S_A_W;
				S_A_W: begin
					drp_q   <= rd_end;
					r_q     <= b_q;
					state_q <= S_A_OUT;
				end
				S_A_OUT: begin
					acc_q.desc_read_slot <= r_q[DESC_AW-1:0];
					acc_q.data_read_byte <= drp_q[DATA_AW-1:0];
					state_q              <= S_DONE;
				end
				S_MON_W: state_q <= S_MON_WW;
				S_MON_WW: begin
					acc_q.latest_time <= rd.time_v;
					acc_q.data_used   <= rd_end;
					acc_q.desc_used   <= CNT_W'(diff);
					state_q           <= S_MON_R;
				end
				S_MON_R: state_q <= S_MON_RW;
				S_MON_RW: begin
					acc_q.data_used <= acc_q.data_used - rd.offset;
					state_q         <= S_DONE;
				end
				S_DONE: begin
					if (!res_valid_q) begin
						res_q       <= acc_q;
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`TWDR_ASSERT(a_fill, (w_q - r_q) <= 64'(DESC_DEPTH), "ring holds more than its depth")
	`TWDR_ASSERT_NEXT(a_hold, res_valid_q && !pop, res_valid_q, "pending result dropped")
	`TWDR_ASSERT(a_wr, !ram_we || (state_q == S_DISP), "slot write outside push")
endmodule

### hdl/time_window_descriptor_ring_unit.sv
// Top level of the time-window descriptor ring unit.
// Depends on twdr_pkg, twdr_front, twdr_back.
//
//  channel   handshake         accepted when
//  request   push / full       push && !full
//  result    empty / pop       pop && !empty
//  config    cfg_we            cfg_we
//
// Find and ack run binary searches in the back end over one memory read port,
// and find then scans the descriptors of its window for an overflow mark.
// The front queue holds two words, so requests queue while the back works.
// arst_n clears indices and handshake state; slot memory is not cleared.
// A result waiting for pop stalls the back end only at its next result.
module time_window_descriptor_ring_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  cmd,
	input  logic [63:0] time_value,
	input  logic [31:0] duration,
	input  logic [63:0] payload_offset,
	input  logic [31:0] data_size,
	input  logic        overflow_mark,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  status,
	output logic [63:0] begin_index,
	output logic [63:0] end_index,
	output logic [10:0] slice_count,
	output logic [63:0] payload_begin,
	output logic [63:0] payload_end,
	output logic        overflow_any,
	output logic [9:0]  desc_read_slot,
	output logic [15:0] data_read_byte,
	output logic [10:0] desc_used,
	output logic [63:0] data_used,
	output logic [63:0] latest_time,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import twdr_pkg::*;

	logic req_valid, req_take, res_valid;
	req_t req_head;
	res_t res;

	twdr_front u_front (
		.clk, .arst_n, .push, .full, .cmd, .time_value, .duration,
		.payload_offset, .data_size, .overflow_mark, .cfg_we, .cfg_index, .cfg_data,
		.req_valid, .req_take, .req_head
	);

	twdr_back u_back (
		.clk, .arst_n, .req_valid, .req_take, .req_head, .res_valid, .pop, .res
	);

	assign empty          = !res_valid;
	assign status         = res.status;
	assign begin_index    = res.begin_index;
	assign end_index      = res.end_index;
	assign slice_count    = res.slice_count;
	assign payload_begin  = res.payload_begin;
	assign payload_end    = res.payload_end;
	assign overflow_any   = res.overflow_any;
	assign desc_read_slot = res.desc_read_slot;
	assign data_read_byte = res.data_read_byte;
	assign desc_used      = res.desc_used;
	assign data_used      = res.data_used;
	assign latest_time    = res.latest_time;
endmodule

### dv/tb_top.sv
// Self-checking testbench for time_window_descriptor_ring_unit.
// Directed table then random phases, checked against an in-bench ring predictor.
// Depends on twdr_pkg and the unit's RTL.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import twdr_pkg::*;

	typedef struct {
		logic [2:0]  cmd;
		logic [63:0] tv;
		logic [31:0] dur;
		logic [63:0] off;
		logic [31:0] size;
		logic        ovf;
	} word_t;

	typedef struct {
		word_t   wd;
		bit      fixed;
		status_t st;
	} row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  cmd = '0;
	logic [63:0] time_value = '0;
	logic [31:0] duration = '0;
	logic [63:0] payload_offset = '0;
	logic [31:0] data_size = '0;
	logic        overflow_mark = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  status;
	logic [63:0] begin_index, end_index, payload_begin, payload_end, data_used, latest_time;
	logic [10:0] slice_count, desc_used;
	logic        overflow_any;
	logic [9:0]  desc_read_slot;
	logic [15:0] data_read_byte;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic [31:0] cfg_data = '0;

	time_window_descriptor_ring_unit dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [63:0] s_time [DESC_DEPTH];
	logic [63:0] s_off  [DESC_DEPTH];
	logic [31:0] s_size [DESC_DEPTH];
	logic        s_ovf  [DESC_DEPTH];
	logic [63:0] rd_pos = '0, wr_pos = '0, data_rd_pos = '0;
	logic [31:0] ov_before = '0, ov_after = '0;

	res_t ring_results_q[$];
	res_t head_res;
	row_t dir_rows[$];
	int   fails = 0;
	bit   idle_on = 1'b1;
	int   stall_left = 0;
	logic [63:0] time_base = 64'd1000;
	logic [63:0] data_base = '0;

	function automatic logic [63:0] end_at(logic [63:0] idx);
		return s_off[idx[9:0]] + {32'b0, s_size[idx[9:0]]};
	endfunction

	function automatic logic [63:0] time_search(logic [63:0] lo, logic [63:0] hi,
			logic [63:0] key, bit upper);
		logic [63:0] first, n, step, m;
		bit right;
		first = lo;
		n = hi - lo;
		while (n > 0) begin
			step = n >> 1;
			m = first + step;
			right = upper ? !(key < s_time[m[9:0]]) : (s_time[m[9:0]] < key);
			if (right) begin
				first = m + 1;
				n = n - step - 1;
			end else begin
				n = step;
			end
		end
		return first;
	endfunction

	function automatic res_t ring_predict(word_t wd);
		res_t o;
		logic [63:0] r, w, lo_t, hi_t, b, e, it, i;
		o = '0;
		r = rd_pos;
		w = wr_pos;
		lo_t = wd.tv - {32'b0, ov_before};
		hi_t = wd.tv + {32'b0, wd.dur} + {32'b0, ov_after};
		case (wd.cmd)
			CMD_PUSH: begin
				if (w - r >= DESC_DEPTH) begin
					o.status = ST_FULL;
				end else begin
					s_time[w[9:0]] = wd.tv;
					s_off[w[9:0]] = wd.off;
					s_size[w[9:0]] = wd.size;
					s_ovf[w[9:0]] = wd.ovf;
					wr_pos = w + 1;
				end
			end
			CMD_CHECK: begin
				if (w == r)
					o.status = ST_TRY_LATER;
				else if (lo_t < s_time[r[9:0]])
					o.status = ST_FAILED;
				else if (hi_t >= s_time[(w - 1) % DESC_DEPTH])
					o.status = ST_TRY_LATER;
			end
			CMD_FIND: begin
				b = time_search(r, w, lo_t, 1'b1);
				if (b == r || b == w) begin
					o.status = ST_OUT_OF_RANGE;
				end else begin
					b = b - 1;
					e = time_search(b, w, hi_t, 1'b0);
					if (e == r || e == w) begin
						o.status = ST_OUT_OF_RANGE;
					end else begin
						o.begin_index = b;
						o.end_index = e;
						o.slice_count = 11'(e - b);
						o.payload_begin = s_off[b[9:0]];
						if (e == b) begin
							o.payload_end = o.payload_begin;
						end else begin
							o.payload_end = end_at(e - 1);
							for (i = b; i != e; i++)
								if (s_ovf[i[9:0]])
									o.overflow_any = 1'b1;
						end
					end
				end
			end
			CMD_ACK: begin
				it = time_search(r, w, lo_t, 1'b1);
				if (it != r) begin
					it = it - 1;
					if (it != r) begin
						data_rd_pos = end_at(it - 1);
						rd_pos = it;
					end
				end
				o.desc_read_slot = rd_pos[9:0];
				o.data_read_byte = data_rd_pos[15:0];
			end
			CMD_MONITOR: begin
				if (w != r) begin
					o.desc_used = 11'(w - r);
					o.data_used = end_at(w - 1) - s_off[r[9:0]];
					o.latest_time = s_time[(w - 1) % DESC_DEPTH];
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	task automatic cmp(string nm, logic [63:0] e, logic [63:0] a);
		if (e !== a) begin
			$error("%s expected %0h actual %0h", nm, e, a);
			fails++;
		end
	endtask

	// result side: check and random pop stalls
	always @(posedge clk) begin
		if (pop && !empty) begin
			if (ring_results_q.size() == 0) begin
				$error("result word with nothing expected");
				fails++;
			end else begin
				head_res = ring_results_q.pop_front();
				cmp("status", head_res.status, status);
				cmp("begin_index", head_res.begin_index, begin_index);
				cmp("end_index", head_res.end_index, end_index);
				cmp("slice_count", head_res.slice_count, slice_count);
				cmp("payload_begin", head_res.payload_begin, payload_begin);
				cmp("payload_end", head_res.payload_end, payload_end);
				cmp("overflow_any", head_res.overflow_any, overflow_any);
				cmp("desc_read_slot", head_res.desc_read_slot, desc_read_slot);
				cmp("data_read_byte", head_res.data_read_byte, data_read_byte);
				cmp("desc_used", head_res.desc_used, desc_used);
				cmp("data_used", head_res.data_used, data_used);
				cmp("latest_time", head_res.latest_time, latest_time);
			end
		end
		if (stall_left > 0) begin
			stall_left--;
			pop <= 1'b0;
		end else if (idle_on && $urandom_range(0, 5) == 0) begin
			stall_left = $urandom_range(0, 2);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	task automatic send_word(word_t wd, bit fixed, status_t st);
		res_t pr;
		cmd <= wd.cmd;
		time_value <= wd.tv;
		duration <= wd.dur;
		payload_offset <= wd.off;
		data_size <= wd.size;
		overflow_mark <= wd.ovf;
		push <= 1'b1;
		do @(posedge clk); while (full);
		pr = ring_predict(wd);
		if (fixed) begin
			pr = '0;
			pr.status = st;
		end
		ring_results_q.insert(ring_results_q.size(), pr);
		if (idle_on && $urandom_range(0, 4) == 0) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	endtask

	task automatic add_row(cmd_t c, logic [63:0] tv, logic [31:0] dur, logic [63:0] off,
			logic [31:0] size, logic ovf, bit fixed, status_t st);
		row_t rw;
		rw.wd = '{c, tv, dur, off, size, ovf};
		rw.fixed = fixed;
		rw.st = st;
		dir_rows.insert(dir_rows.size(), rw);
	endtask

	task automatic set_overlaps(logic [31:0] b, logic [31:0] a);
		push <= 1'b0;
		while (ring_results_q.size() != 0) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_OVERLAP_BEFORE;
		cfg_data <= b;
		@(posedge clk);
		cfg_index <= CFG_OVERLAP_AFTER;
		cfg_data <= a;
		@(posedge clk);
		cfg_we <= 1'b0;
		ov_before = b;
		ov_after = a;
	endtask

	function automatic logic [63:0] pick_window_time();
		logic [63:0] lo, hi, span;
		if (wr_pos == rd_pos)
			return time_base - $urandom_range(0, 3000);
		lo = s_time[rd_pos[9:0]];
		hi = s_time[(wr_pos - 1) % DESC_DEPTH];
		span = hi - lo;
		if (span > 64'd1000000)
			return {$urandom, $urandom};
		return lo - $urandom_range(0, 1500) + $urandom_range(0, 32'(span) + 3000);
	endfunction

	function automatic word_t gen_word(int mode);
		word_t wd;
		int pick;
		wd = '{CMD_MONITOR, {$urandom, $urandom}, $urandom, {$urandom, $urandom},
			$urandom, 1'($urandom)};
		pick = (mode == 1) ? 0 : $urandom_range(0, 99);
		if (mode == 2)
			pick = (pick < 40) ? 75 : pick;
		if (pick < 40) begin
			time_base = time_base + $urandom_range(0, 800);
			wd.cmd = CMD_PUSH;
			wd.tv = time_base;
			wd.off = data_base;
			wd.size = $urandom_range(0, 4000);
			wd.ovf = ($urandom_range(0, 9) == 0);
			data_base = data_base + wd.size;
		end else if (pick < 88) begin
			wd.cmd = (pick < 55) ? CMD_CHECK : (pick < 70) ? CMD_FIND :
				(pick < 80) ? CMD_ACK : CMD_MONITOR;
			wd.tv = pick_window_time();
			wd.dur = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 3000);
		end else begin
			wd.cmd = 3'($urandom_range(0, 7));
			if (wd.cmd == CMD_PUSH)
				wd.tv = time_base;
		end
		return wd;
	endfunction

	initial begin
		int n;
		word_t wd;
		add_row(CMD_MONITOR, 0, 0, 0, 0, 0, 1, ST_OK);
		add_row(CMD_CHECK, 0, 0, 0, 0, 0, 1, ST_TRY_LATER);
		add_row(CMD_FIND, 0, 0, 0, 0, 0, 1, ST_OUT_OF_RANGE);
		add_row(CMD_ACK, '1, '1, 0, 0, 0, 1, ST_OK);
		add_row(cmd_t'(3'd5), 64'd77, 0, 0, 0, 0, 1, ST_OK);
		add_row(cmd_t'(3'd7), '1, '1, '1, '1, 1, 1, ST_OK);
		add_row(CMD_PUSH, 64'd100, 0, 64'd0, 32'd10, 0, 1, ST_OK);
		add_row(CMD_PUSH, 64'd200, 0, 64'd10, 32'd20, 1, 1, ST_OK);
		add_row(CMD_PUSH, 64'd300, '1, 64'd30, '1, 0, 1, ST_OK);
		add_row(CMD_PUSH, 64'd400, 0, '1, 32'd0, 1, 1, ST_OK);
		add_row(CMD_CHECK, 64'd50, 0, 0, 0, 0, 1, ST_FAILED);
		add_row(CMD_CHECK, 64'd150, 32'd10, 0, 0, 0, 0, ST_OK);
		add_row(CMD_CHECK, 64'd350, 32'd100, 0, 0, 0, 1, ST_TRY_LATER);
		add_row(CMD_FIND, 64'd150, 32'd100, 0, 0, 0, 0, ST_OK);
		add_row(CMD_FIND, 64'd200, 32'd0, 0, 0, 0, 0, ST_OK);
		add_row(CMD_FIND, 64'd50, 32'd10, 0, 0, 0, 1, ST_OUT_OF_RANGE);
		add_row(CMD_FIND, 64'd350, 32'd200, 0, 0, 0, 1, ST_OUT_OF_RANGE);
		add_row(CMD_FIND, '1, '1, 0, 0, 0, 1, ST_OUT_OF_RANGE);
		add_row(CMD_MONITOR, 0, 0, 0, 0, 0, 0, ST_OK);
		add_row(CMD_ACK, 64'd250, 0, 0, 0, 0, 0, ST_OK);
		add_row(CMD_ACK, 64'd50, 0, 0, 0, 0, 0, ST_OK);
		add_row(CMD_MONITOR, 0, 0, 0, 0, 0, 0, ST_OK);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_rows[k])
			send_word(dir_rows[k].wd, dir_rows[k].fixed, dir_rows[k].st);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_overlaps(32'd0, 32'd0);
				1: set_overlaps('1, '1);
				2: set_overlaps(32'd500, 32'd300);
				3: set_overlaps(32'd0, '1);
				4: set_overlaps('1, 32'd0);
				5: set_overlaps($urandom, $urandom);
				6: set_overlaps(32'd0, 32'd0);
				default: set_overlaps($urandom_range(0, 2000), $urandom_range(0, 2000));
			endcase
			idle_on = (ph != 7);
			n = (ph == 6) ? 1200 : 90;
			for (int k = 0; k < n; k++) begin
				// phase 6 fills the ring: pushes until past full, then acks mixed with other commands
				wd = gen_word((ph == 6) ? ((k < 1040) ? 1 : 2) : 0);
				send_word(wd, 1'b0, ST_OK);
			end
		end
		push <= 1'b0;
		while (ring_results_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fails == 0)
			$display("PASS time_window_descriptor_ring_unit");
		else
			$display("FAIL time_window_descriptor_ring_unit");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAIL time_window_descriptor_ring_unit");
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/twdr_pkg.sv
hdl/twdr_ram.sv
hdl/twdr_front.sv
hdl/twdr_back.sv
hdl/time_window_descriptor_ring_unit.sv
dv/tb_top.sv
